FILE: design/izh_pkg.sv
package izh_pkg;

    localparam int N_CELLS  = 1024;
    localparam int DT_SHIFT = 1;

    localparam int Q_W      = 32;
    localparam int CELL_W   = 10;
    localparam int ADDR_CLG = (N_CELLS > 1) ? $clog2(N_CELLS) : 1;
    localparam int ADDR_W   = (ADDR_CLG > CELL_W) ? CELL_W : ADDR_CLG;

    localparam int NREG     = 8;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_QUAD  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LIN   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BIAS  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_RATE  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_GAIN  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_LEVEL = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_STEP  = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_THR   = 3'd7;

    localparam logic signed [Q_W-1:0] CFG_RESET [NREG] = '{
        32'sd2621, 32'sd327680, 32'sd9830400, 32'sd1311,
        32'sd13107, -32'sd4259840, 32'sd524288, 32'sd1966080
    };

    localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

    // Sequencer step codes.
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] ST_IDLE  = 4'd0;
    localparam logic [STEP_W-1:0] ST_FIRST = 4'd1;
    localparam logic [STEP_W-1:0] ST_SPK   = 4'd7;
    localparam logic [STEP_W-1:0] ST_SHORT = 4'd8;

    typedef logic [2:0] mul_op_t;
    localparam mul_op_t MUL_NONE = 3'd0;
    localparam mul_op_t MUL_VV   = 3'd1;
    localparam mul_op_t MUL_BV   = 3'd2;
    localparam mul_op_t MUL_LV   = 3'd3;
    localparam mul_op_t MUL_QVV  = 3'd4;
    localparam mul_op_t MUL_AE   = 3'd5;

    typedef logic [2:0] alu_op_t;
    localparam alu_op_t ALU_NONE = 3'd0;
    localparam alu_op_t ALU_VV   = 3'd1;
    localparam alu_op_t ALU_E    = 3'd2;
    localparam alu_op_t ALU_T    = 3'd3;
    localparam alu_op_t ALU_NV   = 3'd4;
    localparam alu_op_t ALU_NU   = 3'd5;
    localparam alu_op_t ALU_SPK  = 3'd6;
    localparam alu_op_t ALU_LOAD = 3'd7;

    typedef logic [1:0] seq_op_t;
    localparam seq_op_t SEQ_WAIT = 2'd0;
    localparam seq_op_t SEQ_NEXT = 2'd1;
    localparam seq_op_t SEQ_END  = 2'd2;

    typedef struct packed {
        mul_op_t mul;
        alu_op_t alu;
        seq_op_t seq;
    } ctrl_t;

    // Microprogram: one control word per step.
    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        ctrl_t w;
        unique case (step)
            4'd0:    w = '{mul: MUL_NONE, alu: ALU_NONE, seq: SEQ_WAIT};
            4'd1:    w = '{mul: MUL_VV,   alu: ALU_NONE, seq: SEQ_NEXT};
            4'd2:    w = '{mul: MUL_BV,   alu: ALU_VV,   seq: SEQ_NEXT};
            4'd3:    w = '{mul: MUL_LV,   alu: ALU_E,    seq: SEQ_NEXT};
            4'd4:    w = '{mul: MUL_QVV,  alu: ALU_T,    seq: SEQ_NEXT};
            4'd5:    w = '{mul: MUL_AE,   alu: ALU_NV,   seq: SEQ_NEXT};
            4'd6:    w = '{mul: MUL_NONE, alu: ALU_NU,   seq: SEQ_NEXT};
            4'd7:    w = '{mul: MUL_NONE, alu: ALU_SPK,  seq: SEQ_END};
            4'd8:    w = '{mul: MUL_NONE, alu: ALU_LOAD, seq: SEQ_END};
            default: w = '{mul: MUL_NONE, alu: ALU_NONE, seq: SEQ_END};
        endcase
        return w;
    endfunction

    // Saturate a 34-bit sum to Q16.16.
    function automatic logic signed [Q_W-1:0] sat34(input logic signed [33:0] x);
        logic signed [Q_W-1:0] r;
        if (x[33:31] == 3'b000 || x[33:31] == 3'b111)
            r = x[Q_W-1:0];
        else if (x[33])
            r = Q_MIN;
        else
            r = Q_MAX;
        return r;
    endfunction

    // Floor-shift a full product by 16 and saturate to Q16.16.
    function automatic logic signed [Q_W-1:0] qsat(input logic signed [63:0] p);
        logic signed [Q_W-1:0] r;
        if ((&p[63:47]) || !(|p[63:47]))
            r = p[47:16];
        else if (p[63])
            r = Q_MIN;
        else
            r = Q_MAX;
        return r;
    endfunction

endpackage

FILE: design/izhikevich_neuron_update_core.sv
// A step beat runs the full update program; a load beat or an out-of-range beat runs
// only the load step. Busy stays high while a program runs, so a new beat is taken only
// once the last one has finished its program; the shared 32x32 multiplier, used by
// five dependent products, sets the length of the step program.
// Reset clears the sequencer, the result strobe and the coefficient registers to
// their defaults; cell state is undefined until loaded. Results cannot be stalled.
module izhikevich_neuron_update_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                func,
    input  logic [izh_pkg::CELL_W-1:0]          cell_req,
    input  logic signed [izh_pkg::Q_W-1:0]      load_v,
    input  logic signed [izh_pkg::Q_W-1:0]      load_u,
    input  logic                                cfg_we,
    input  logic [izh_pkg::REG_IDX_W-1:0]       cfg_index,
    input  logic [izh_pkg::Q_W-1:0]             cfg_data,
    output logic                                done,
    output logic [izh_pkg::CELL_W-1:0]          out_cell,
    output logic signed [izh_pkg::Q_W-1:0]      new_v,
    output logic signed [izh_pkg::Q_W-1:0]      new_u,
    output logic                                spike
);

    logic signed [izh_pkg::Q_W-1:0] cfg_reg [izh_pkg::NREG];

    logic signed [izh_pkg::Q_W-1:0] mem_v [izh_pkg::N_CELLS];
    logic signed [izh_pkg::Q_W-1:0] mem_u [izh_pkg::N_CELLS];

    logic [izh_pkg::STEP_W-1:0]     step_reg, step_next;
    izh_pkg::ctrl_t                 ctrl;
    logic                           accept;
    logic                           in_range_c;

    logic                           func_reg;
    logic                           in_range_reg;
    logic [izh_pkg::CELL_W-1:0]     cell_reg;
    logic signed [izh_pkg::Q_W-1:0] load_v_reg, load_u_reg;
    logic signed [izh_pkg::Q_W-1:0] v_reg, u_reg;

    logic signed [63:0]             prod_reg;
    logic signed [izh_pkg::Q_W-1:0] mul_a, mul_b;
    logic signed [izh_pkg::Q_W-1:0] prod_q;

    logic signed [izh_pkg::Q_W-1:0] vv_reg, e_reg, nv_reg, nu_reg;
    logic signed [33:0]             t_reg;
    logic signed [izh_pkg::Q_W-1:0] s_c, dv_c, du_c;

    logic                           spk_c;
    logic signed [izh_pkg::Q_W-1:0] res_v_c, res_u_c;
    logic                           mem_we;

    logic                           done_reg;
    logic [izh_pkg::CELL_W-1:0]     out_cell_reg;
    logic signed [izh_pkg::Q_W-1:0] new_v_reg, new_u_reg;
    logic                           spike_reg;

    assign ctrl       = izh_pkg::ucode(step_reg);
    assign busy       = (step_reg != izh_pkg::ST_IDLE);
    assign accept     = start && !busy;
    assign in_range_c = (32'(cell_req) < 32'(izh_pkg::N_CELLS));

    always_comb
    begin
        unique case (ctrl.seq)
            izh_pkg::SEQ_WAIT:
            begin
                if (accept)
                    step_next = (func && in_range_c) ? izh_pkg::ST_FIRST : izh_pkg::ST_SHORT;
                else
                    step_next = izh_pkg::ST_IDLE;
            end
            izh_pkg::SEQ_NEXT: step_next = step_reg + 1'b1;
            default:           step_next = izh_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= izh_pkg::ST_IDLE;
            done_reg <= 1'b0;
            for (int i = 0; i < izh_pkg::NREG; i++)
                cfg_reg[i] <= izh_pkg::CFG_RESET[i];
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= (ctrl.seq == izh_pkg::SEQ_END);
            if (cfg_we)
                cfg_reg[cfg_index] <= $signed(cfg_data);
        end
    end

    // Cell state memories: one read at accept, one write at the end of an in-range item.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_v[cell_reg[izh_pkg::ADDR_W-1:0]] <= res_v_c;
            mem_u[cell_reg[izh_pkg::ADDR_W-1:0]] <= res_u_c;
        end
        if (accept)
        begin
            v_reg <= mem_v[cell_req[izh_pkg::ADDR_W-1:0]];
            u_reg <= mem_u[cell_req[izh_pkg::ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg     <= func;
            in_range_reg <= in_range_c;
            cell_reg     <= cell_req;
            load_v_reg   <= load_v;
            load_u_reg   <= load_u;
        end
    end

    always_comb
    begin
        unique case (ctrl.mul)
            izh_pkg::MUL_VV:
            begin
                mul_a = v_reg;
                mul_b = v_reg;
            end
            izh_pkg::MUL_BV:
            begin
                mul_a = cfg_reg[izh_pkg::REG_GAIN];
                mul_b = v_reg;
            end
            izh_pkg::MUL_LV:
            begin
                mul_a = cfg_reg[izh_pkg::REG_LIN];
                mul_b = v_reg;
            end
            izh_pkg::MUL_QVV:
            begin
                mul_a = cfg_reg[izh_pkg::REG_QUAD];
                mul_b = vv_reg;
            end
            izh_pkg::MUL_AE:
            begin
                mul_a = cfg_reg[izh_pkg::REG_RATE];
                mul_b = e_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul != izh_pkg::MUL_NONE)
            prod_reg <= mul_a * mul_b;
    end

    assign prod_q = izh_pkg::qsat(prod_reg);

    // Right shifts of signed values floor, matching the Euler step scaling by dt.
    assign s_c  = izh_pkg::sat34(34'(prod_q) + t_reg);
    assign dv_c = s_c >>> izh_pkg::DT_SHIFT;
    assign du_c = prod_q >>> izh_pkg::DT_SHIFT;

    always_ff @(posedge clk)
    begin
        unique case (ctrl.alu)
            izh_pkg::ALU_VV: vv_reg <= prod_q;
            izh_pkg::ALU_E:  e_reg  <= izh_pkg::sat34(34'(prod_q) - 34'(u_reg));
            izh_pkg::ALU_T:  t_reg  <= 34'(prod_q) + 34'(cfg_reg[izh_pkg::REG_BIAS])
                                       - 34'(u_reg);
            izh_pkg::ALU_NV: nv_reg <= izh_pkg::sat34(34'(v_reg) + 34'(dv_c));
            izh_pkg::ALU_NU: nu_reg <= izh_pkg::sat34(34'(u_reg) + 34'(du_c));
            default:         ;
        endcase
    end

    assign spk_c = (ctrl.alu == izh_pkg::ALU_SPK) && (nv_reg > cfg_reg[izh_pkg::REG_THR]);

    always_comb
    begin
        if (ctrl.alu == izh_pkg::ALU_LOAD)
        begin
            res_v_c = in_range_reg ? load_v_reg : '0;
            res_u_c = in_range_reg ? load_u_reg : '0;
        end
        else if (spk_c)
        begin
            res_v_c = cfg_reg[izh_pkg::REG_LEVEL];
            res_u_c = izh_pkg::sat34(34'(nu_reg) + 34'(cfg_reg[izh_pkg::REG_STEP]));
        end
        else
        begin
            res_v_c = nv_reg;
            res_u_c = nu_reg;
        end
    end

    assign mem_we = (ctrl.alu == izh_pkg::ALU_SPK) ||
                    ((ctrl.alu == izh_pkg::ALU_LOAD) && in_range_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.seq == izh_pkg::SEQ_END)
        begin
            out_cell_reg <= cell_reg;
            new_v_reg    <= res_v_c;
            new_u_reg    <= res_u_c;
            spike_reg    <= spk_c;
        end
    end

    assign done     = done_reg;
    assign out_cell = out_cell_reg;
    assign new_v    = new_v_reg;
    assign new_u    = new_u_reg;
    assign spike    = spike_reg;

    a_done_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(ctrl.seq == izh_pkg::SEQ_END))
        else $error("result strobe without an end step");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted beat did not occupy the sequencer");

    a_spk_step_only: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == izh_pkg::ST_SPK) |-> (func_reg && in_range_reg))
        else $error("update program ran for a load or out-of-range beat");

    a_spike_step: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && spike_reg) |-> func_reg)
        else $error("spike reported for a load beat");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= izh_pkg::ST_SHORT)
        else $error("step counter left the program");

endmodule

FILE: verif/izh_tb_pkg.sv
package izh_tb_pkg;

    // Meaning of the func input of a beat.
    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } cell_op_e;

endpackage

FILE: verif/izh_update_checker.sv
module izh_update_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  logic                           func,
    input  logic [izh_pkg::CELL_W-1:0]     cell_req,
    input  logic signed [izh_pkg::Q_W-1:0] load_v,
    input  logic signed [izh_pkg::Q_W-1:0] load_u,
    input  logic                           cfg_we,
    input  logic [izh_pkg::REG_IDX_W-1:0]  cfg_index,
    input  logic [izh_pkg::Q_W-1:0]        cfg_data,
    input  logic                           done,
    input  logic [izh_pkg::CELL_W-1:0]     out_cell,
    input  logic signed [izh_pkg::Q_W-1:0] new_v,
    input  logic signed [izh_pkg::Q_W-1:0] new_u,
    input  logic                           spike,
    output int                             mismatch_count,
    output int                             outstanding,
    output int                             spikes_predicted
);
    import izh_pkg::*;
    import izh_tb_pkg::*;

    typedef struct {
        logic [CELL_W-1:0]     cell_id;
        logic signed [Q_W-1:0] v;
        logic signed [Q_W-1:0] u;
        logic                  spk;
    } cell_result_t;

    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;

    logic signed [Q_W-1:0] coef [NREG];
    logic signed [Q_W-1:0] membrane [N_CELLS];
    logic signed [Q_W-1:0] recovery [N_CELLS];
    cell_result_t          pending_results [$];
    cell_result_t          oldest;
    cell_result_t          predicted;

    function automatic logic signed [Q_W-1:0] sat_q(input longint x);
        if (x > SAT_HI)
            return Q_MAX;
        if (x < SAT_LO)
            return Q_MIN;
        return x[Q_W-1:0];
    endfunction

    // The arithmetic shift of the exact product floors toward minus infinity.
    function automatic logic signed [Q_W-1:0] mul_q(input logic signed [Q_W-1:0] a,
                                                    input logic signed [Q_W-1:0] b);
        longint p;
        p = (longint'(a) * longint'(b)) >>> 16;
        return sat_q(p);
    endfunction

    // Updates the shadow cell state for one beat and returns the result it should give.
    function automatic cell_result_t apply_beat(input logic op,
                                                input logic [CELL_W-1:0] cell_idx,
                                                input logic signed [Q_W-1:0] lv,
                                                input logic signed [Q_W-1:0] lu);
        cell_result_t          r;
        logic signed [Q_W-1:0] v, u, vv, p1, p2, s, bv, e, ae;
        r.cell_id = cell_idx;
        r.v       = '0;
        r.u       = '0;
        r.spk     = 1'b0;
        if (int'(cell_idx) >= N_CELLS)
            return r;
        if (op == OP_LOAD)
        begin
            r.v = lv;
            r.u = lu;
        end
        else
        begin
            v  = membrane[cell_idx];
            u  = recovery[cell_idx];
            vv = mul_q(v, v);
            p1 = mul_q(coef[REG_QUAD], vv);
            p2 = mul_q(coef[REG_LIN], v);
            s  = sat_q(longint'(p1) + longint'(p2) + longint'(coef[REG_BIAS]) - longint'(u));
            r.v = sat_q(longint'(v) + (longint'(s) >>> DT_SHIFT));
            bv = mul_q(coef[REG_GAIN], v);
            e  = sat_q(longint'(bv) - longint'(u));
            ae = mul_q(coef[REG_RATE], e);
            r.u = sat_q(longint'(u) + (longint'(ae) >>> DT_SHIFT));
            if (r.v > coef[REG_THR])
            begin
                r.v   = coef[REG_LEVEL];
                r.u   = sat_q(longint'(r.u) + longint'(coef[REG_STEP]));
                r.spk = 1'b1;
            end
        end
        membrane[cell_idx] = r.v;
        recovery[cell_idx] = r.u;
        return r;
    endfunction

    // A result can never belong to a beat taken at the same edge, so it is
    // checked before that edge's beat is predicted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NREG; i++)
                coef[i] = CFG_RESET[i];
            pending_results.delete();
            mismatch_count   = 0;
            spikes_predicted = 0;
            outstanding     <= 0;
        end
        else
        begin
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result for cell %0d arrived with nothing expected", out_cell);
                    mismatch_count++;
                end
                else
                begin
                    oldest = pending_results.pop_front();
                    if (out_cell !== oldest.cell_id)
                    begin
                        $error("out_cell: expected %0d, got %0d", oldest.cell_id, out_cell);
                        mismatch_count++;
                    end
                    if (new_v !== oldest.v)
                    begin
                        $error("new_v: expected %0d, got %0d", oldest.v, new_v);
                        mismatch_count++;
                    end
                    if (new_u !== oldest.u)
                    begin
                        $error("new_u: expected %0d, got %0d", oldest.u, new_u);
                        mismatch_count++;
                    end
                    if (spike !== oldest.spk)
                    begin
                        $error("spike: expected %0d, got %0d", oldest.spk, spike);
                        mismatch_count++;
                    end
                end
            end
            if (cfg_we)
                coef[cfg_index] = cfg_data;
            if (start && !busy)
            begin
                predicted = apply_beat(func, cell_req, load_v, load_u);
                if (predicted.spk)
                    spikes_predicted++;
                pending_results.push_back(predicted);
            end
            outstanding <= pending_results.size();
        end
    end

endmodule

FILE: verif/testbench.sv
module testbench;
    import izh_pkg::*;
    import izh_tb_pkg::*;

    localparam int RANDOM_PER_PHASE = 140;
    localparam int NUM_PHASES       = 11;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int SETTLE_CYCLES    = 10;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    logic                  busy;
    logic                  func      = OP_LOAD;
    logic [CELL_W-1:0]     cell_req  = '0;
    logic signed [Q_W-1:0] load_v    = '0;
    logic signed [Q_W-1:0] load_u    = '0;
    logic                  cfg_we    = 1'b0;
    logic [REG_IDX_W-1:0]  cfg_index = '0;
    logic [Q_W-1:0]        cfg_data  = '0;
    logic                  done;
    logic [CELL_W-1:0]     out_cell;
    logic signed [Q_W-1:0] new_v;
    logic signed [Q_W-1:0] new_u;
    logic                  spike;

    int mismatch_count;
    int outstanding;
    int spikes_predicted;

    bit                cell_written [N_CELLS];
    int                n_loads     = 0;
    int                n_steps     = 0;
    int                burst_left  = 0;
    int                idle_cycles = 0;
    int                pool [8];
    logic [CELL_W-1:0] cell_sel;

    izhikevich_neuron_update_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .func      (func),
        .cell_req  (cell_req),
        .load_v    (load_v),
        .load_u    (load_u),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .out_cell  (out_cell),
        .new_v     (new_v),
        .new_u     (new_u),
        .spike     (spike)
    );

    izh_update_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .func             (func),
        .cell_req         (cell_req),
        .load_v           (load_v),
        .load_u           (load_u),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .done             (done),
        .out_cell         (out_cell),
        .new_v            (new_v),
        .new_u            (new_u),
        .spike            (spike),
        .mismatch_count   (mismatch_count),
        .outstanding      (outstanding),
        .spikes_predicted (spikes_predicted)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_we)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Mostly values in the physiological window, with some raw bit patterns and rails.
    function automatic logic signed [Q_W-1:0] random_state(input int unsigned span,
                                                           input int offset);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return int'($urandom_range(0, span)) - offset;
            6, 7:             return $urandom;
            8:                return Q_MAX;
            default:          return Q_MIN;
        endcase
    endfunction

    function automatic logic [Q_W-1:0] phase_coef(input int phase,
                                                  input logic [REG_IDX_W-1:0] idx);
        logic [Q_W-1:0] val;
        val = CFG_RESET[idx];
        case (phase)
            // Regular spiking with the input current moved by up to 20 either way.
            1: if (idx == REG_BIAS)
                   val = CFG_RESET[REG_BIAS] + int'($urandom_range(0, 2621440)) - 1310720;
            // Chattering: reset to -50 and a recovery kick of 2.
            2: if (idx == REG_LEVEL)
                   val = -32'sd3276800;
               else if (idx == REG_STEP)
                   val = 32'sd131072;
            // Fast spiking: recovery rate 0.1 and a kick of 2.
            3: if (idx == REG_RATE)
                   val = 32'sd6554;
               else if (idx == REG_STEP)
                   val = 32'sd131072;
            4: val = Q_MAX;
            5: val = Q_MIN;
            6: val = $urandom;
            // The lowest threshold fires on almost every step.
            7: if (idx == REG_THR)
                   val = Q_MIN;
            8: val = '0;
            // Nothing can exceed the highest threshold.
            9: if (idx == REG_THR)
                   val = Q_MAX;
               else if (idx == REG_BIAS)
                   val = $urandom;
               else
                   val = int'($urandom_range(0, 131072)) - 65536;
            default: ;
        endcase
        return val;
    endfunction

    task automatic send_beat(input cell_op_e op, input logic [CELL_W-1:0] target,
                             input logic signed [Q_W-1:0] v, input logic signed [Q_W-1:0] u);
        int gap;
        if (burst_left > 0)
        begin
            gap = 0;
            burst_left--;
        end
        else if ($urandom_range(0, 15) == 0)
        begin
            burst_left = $urandom_range(10, 40);
            gap = 0;
        end
        else
            gap = $urandom_range(0, 17);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        func     <= op;
        cell_req <= target;
        load_v   <= v;
        load_u   <= u;
        do
            @(posedge clk);
        while (busy);
        if (op == OP_LOAD)
        begin
            cell_written[target] = 1'b1;
            n_loads++;
        end
        else
            n_steps++;
    endtask

    // One edge first, so that the checker's count includes the beat just taken.
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0 || busy)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_phase(input int phase);
        for (int i = 0; i < NREG; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_IDX_W'(i);
            cfg_data  <= phase_coef(phase, REG_IDX_W'(i));
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats under the reset coefficients.
        send_beat(OP_LOAD, 10'd0, -32'sd4259840, -32'sd851968);
        send_beat(OP_STEP, 10'd0, '0, '0);
        send_beat(OP_STEP, 10'd0, '1, '1);
        send_beat(OP_STEP, 10'd0, '0, '0);
        send_beat(OP_LOAD, 10'd1023, Q_MAX, Q_MAX);
        send_beat(OP_STEP, 10'd1023, '0, '0);
        send_beat(OP_LOAD, 10'd512, Q_MIN, Q_MIN);
        send_beat(OP_STEP, 10'd512, '0, '0);
        send_beat(OP_LOAD, 10'd341, Q_MIN, Q_MAX);
        send_beat(OP_STEP, 10'd341, '0, '0);
        send_beat(OP_LOAD, 10'd682, Q_MAX, Q_MIN);
        send_beat(OP_STEP, 10'd682, '0, '0);
        send_beat(OP_LOAD, 10'd1, '0, '0);
        send_beat(OP_STEP, 10'd1, '0, '0);
        // Just under threshold, so the step fires.
        send_beat(OP_LOAD, 10'd2, 32'sd1933312, '0);
        send_beat(OP_STEP, 10'd2, '0, '0);
        // Same v as above but u near the top, so the large u pulls v down and the step does not fire.
        send_beat(OP_LOAD, 10'd3, 32'sd1933312, 32'sh7FFF_0000);
        send_beat(OP_STEP, 10'd3, '0, '0);
        send_beat(OP_LOAD, 10'd4, 32'shAAAA_AAAA, 32'sh5555_5555);
        send_beat(OP_STEP, 10'd4, '0, '0);
        send_beat(OP_LOAD, 10'd5, 32'sh5555_5555, 32'shAAAA_AAAA);
        send_beat(OP_STEP, 10'd5, '0, '0);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase > 0)
            begin
                settle();
                program_phase(phase);
            end
            // A few cells per phase are stepped over and over to get spike trains.
            for (int k = 0; k < 8; k++)
                pool[k] = $urandom_range(0, N_CELLS - 1);
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                cell_sel = CELL_W'(pool[$urandom_range(0, 7)]);
                if ($urandom_range(0, 19) == 0)
                    cell_sel = CELL_W'($urandom_range(0, N_CELLS - 1));
                if (!cell_written[cell_sel] || $urandom_range(0, 9) < 2)
                    send_beat(OP_LOAD, cell_sel, random_state(7208960, 5242880),
                              random_state(1966080, 1310720));
                else
                    send_beat(OP_STEP, cell_sel, $urandom, $urandom);
            end
        end

        settle();
        $display("Covered %0d load beats and %0d step beats over %0d coefficient settings,",
                 n_loads, n_steps, NUM_PHASES);
        $display("with %0d spikes among the predicted results.", spikes_predicted);
        if (mismatch_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
